FILE: hw/rtl/lglm_pkg.sv
// Shared types and constants of the light gate length meter.
// Used by lglm_ctrl, lglm_dp and light_gate_length_meter; depends on nothing.

package lglm_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned LevelW  = 10;
  localparam int unsigned StampW  = 32;
  localparam int unsigned SizeW   = 16;
  localparam int unsigned DivW    = 16;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 16;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;

  localparam int unsigned StepCntW = $clog2(StampW);

  localparam logic [OpW-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OpW-1:0] OP_PAUSE  = 2'd1;
  localparam logic [OpW-1:0] OP_RESUME = 2'd2;

  localparam logic [PhaseW-1:0] PHASE_IDLE      = 2'd0;
  localparam logic [PhaseW-1:0] PHASE_MEASURING = 2'd1;
  localparam logic [PhaseW-1:0] PHASE_HELD      = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_LIGHT_THRESHOLD = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_MS_PER_UNIT     = 1'd1;

  localparam logic [LevelW-1:0] THRESHOLD_RESET = 10'd500;
  localparam logic [DivW-1:0]   MS_PER_UNIT_RESET = 16'd100;

  localparam logic [SizeW-1:0] SIZE_MAX = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic div_finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stop_hit;
  } dp_status_t;

endpackage

FILE: hw/rtl/light_gate_length_meter.sv
// Light gate length meter: an item is taken on a handshake and its result is
// offered on the output stream in the next cycle; the output register frees
// as soon as the result transfer happens, so items can follow every cycle
// unless the output stalls. A sample that stops timing also runs the 32-step
// restoring divider and a rounding step, blocking the input until both end.
// Reset (rst_ni low, async) sets idle and defaults; result and divider regs have none.

module light_gate_length_meter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lglm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [lglm_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [9:0] light_level, [41:10] now_ms, [47:42] zero
  input  logic [lglm_pkg::InDataW-1:0]      s_axis_tdata,
  // [1:0] operation
  input  logic [lglm_pkg::OpW-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] object_size
  output logic [lglm_pkg::OutDataW-1:0]     m_axis_tdata,
  // [0] object_valid
  output logic                              m_axis_tuser
);

  lglm_pkg::dp_cmd_t    cmd;
  lglm_pkg::dp_status_t status;
  logic [lglm_pkg::SizeW-1:0] object_size;

  lglm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  lglm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (s_axis_tuser),
    .light_level_i  (s_axis_tdata[lglm_pkg::LevelW-1:0]),
    .now_ms_i       (s_axis_tdata[lglm_pkg::LevelW +: lglm_pkg::StampW]),
    .cmd_i          (cmd),
    .status_o       (status),
    .object_valid_o (m_axis_tuser),
    .object_size_o  (object_size)
  );

  assign m_axis_tdata = object_size;

endmodule

FILE: hw/rtl/lglm_ctrl.sv
// Controller of the light gate length meter: input/output handshake and the
// sequencing of the bit-serial divider. Depends on lglm_pkg.

module lglm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lglm_pkg::dp_cmd_t     cmd_o,
  input  lglm_pkg::dp_status_t  status_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [lglm_pkg::StepCntW-1:0]   cnt_q, cnt_d;
  logic                            out_vld_q, out_vld_d;
  logic                            accept;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_vld_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;

  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    cmd_o.accept     = accept;
    cmd_o.div_step   = 1'b0;
    cmd_o.div_finish = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && status_i.stop_hit) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.div_finish = 1'b1;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Every accepted item yields exactly one result transfer.
  always_comb begin
    out_vld_d = out_vld_q;
    if (accept) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

FILE: hw/rtl/lglm_dp.sv
// Datapath of the light gate length meter: configuration registers, gate
// phase, time stamps, restoring divider and result register. Depends on lglm_pkg.

module lglm_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lglm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [lglm_pkg::CfgW-1:0]        cfg_wdata_i,
  input  logic [lglm_pkg::OpW-1:0]         operation_i,
  input  logic [lglm_pkg::LevelW-1:0]      light_level_i,
  input  logic [lglm_pkg::StampW-1:0]      now_ms_i,
  input  lglm_pkg::dp_cmd_t                cmd_i,
  output lglm_pkg::dp_status_t             status_o,
  output logic                             object_valid_o,
  output logic [lglm_pkg::SizeW-1:0]       object_size_o
);

  logic [lglm_pkg::LevelW-1:0] thr_q;
  logic [lglm_pkg::DivW-1:0]   div_q;
  logic [lglm_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [lglm_pkg::StampW-1:0] start_q, start_d;
  logic [lglm_pkg::StampW-1:0] pause_q, pause_d;
  logic [lglm_pkg::SizeW-1:0]  held_q, held_d;
  logic [lglm_pkg::StampW-1:0] quo_q, quo_d;
  logic [lglm_pkg::DivW-1:0]   rem_q, rem_d;
  logic                        ovld_q, ovld_d;
  logic [lglm_pkg::SizeW-1:0]  osize_q, osize_d;

  logic                        is_sample;
  logic [lglm_pkg::DivW:0]     rem_sh;
  logic                        ge;
  logic [lglm_pkg::DivW:0]     rem_sub;
  logic                        round_up;
  logic [lglm_pkg::StampW:0]   quo_rnd;
  logic [lglm_pkg::SizeW-1:0]  size_fin;

  assign is_sample = (operation_i == lglm_pkg::OP_SAMPLE);
  assign status_o.stop_hit = is_sample && (phase_q == lglm_pkg::PHASE_MEASURING)
                             && (light_level_i > thr_q);

  // One quotient bit per step; the remainder stays below the divisor while it is nonzero and unchanged.
  assign rem_sh  = {rem_q, quo_q[lglm_pkg::StampW-1]};
  assign ge      = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  assign round_up = {rem_q, 1'b0} > {1'b0, div_q};
  assign quo_rnd  = {1'b0, quo_q} + {{lglm_pkg::StampW{1'b0}}, round_up};
  always_comb begin
    if (div_q == '0 || quo_rnd > {{(lglm_pkg::StampW + 1 - lglm_pkg::SizeW){1'b0}},
                                  lglm_pkg::SIZE_MAX}) begin
      size_fin = lglm_pkg::SIZE_MAX;
    end else begin
      size_fin = quo_rnd[lglm_pkg::SizeW-1:0];
    end
  end

  always_comb begin
    phase_d = phase_q;
    start_d = start_q;
    pause_d = pause_q;
    held_d  = held_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    ovld_d  = ovld_q;
    osize_d = osize_q;

    if (cmd_i.accept) begin
      ovld_d  = 1'b0;
      osize_d = '0;
      case (operation_i)
        lglm_pkg::OP_SAMPLE: begin
          if (phase_q == lglm_pkg::PHASE_MEASURING) begin
            if (status_o.stop_hit) begin
              phase_d = lglm_pkg::PHASE_HELD;
              quo_d   = now_ms_i - start_q;
              rem_d   = '0;
            end
          end else if (phase_q == lglm_pkg::PHASE_HELD) begin
            ovld_d  = 1'b1;
            osize_d = held_q;
            held_d  = '0;
            phase_d = lglm_pkg::PHASE_IDLE;
          end else begin
            phase_d = lglm_pkg::PHASE_IDLE;
            if (light_level_i != '0 && light_level_i < thr_q) begin
              start_d = now_ms_i;
              phase_d = lglm_pkg::PHASE_MEASURING;
            end
          end
        end
        lglm_pkg::OP_PAUSE: begin
          pause_d = now_ms_i;
        end
        lglm_pkg::OP_RESUME: begin
          start_d = start_q + (now_ms_i - pause_q);
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.div_step) begin
      quo_d = {quo_q[lglm_pkg::StampW-2:0], ge};
      rem_d = ge ? rem_sub[lglm_pkg::DivW-1:0] : rem_sh[lglm_pkg::DivW-1:0];
    end

    if (cmd_i.div_finish) begin
      held_d = size_fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= lglm_pkg::THRESHOLD_RESET;
      div_q   <= lglm_pkg::MS_PER_UNIT_RESET;
      phase_q <= lglm_pkg::PHASE_IDLE;
      start_q <= '0;
      pause_q <= '0;
      held_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lglm_pkg::CFG_LIGHT_THRESHOLD: thr_q <= cfg_wdata_i[lglm_pkg::LevelW-1:0];
          lglm_pkg::CFG_MS_PER_UNIT:     div_q <= cfg_wdata_i[lglm_pkg::DivW-1:0];
          default: begin
          end
        endcase
      end
      phase_q <= phase_d;
      start_q <= start_d;
      pause_q <= pause_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    ovld_q  <= ovld_d;
    osize_q <= osize_d;
  end

  assign object_valid_o = ovld_q;
  assign object_size_o  = osize_q;

endmodule
